FILE: sv/fosf_pkg.sv
// fosf_pkg: widths, defaults and register indexes of the shelving filter.
// No dependencies; used by the interfaces and the top level.
package fosf_pkg;

	localparam int DEF_CHANNELS    = 8;
	localparam int DEF_SAMPLE_BITS = 24;

	localparam int CHAN_W     = 3;
	localparam int COEF_W     = 23;
	localparam int GAIN_W     = 20;
	localparam int KIND_W     = 1;
	localparam int DLY_W      = 32;
	localparam int COEF_FRAC  = 22;
	localparam int GAIN_FRAC  = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_COEFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KIND  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_HIGH = 1'b1;

endpackage

FILE: sv/fosf_in_if.sv
// fosf_in_if: input sample channel (valid/ready, sample and channel number).
// Depends on fosf_pkg.
interface fosf_in_if
	import fosf_pkg::*;
	#(parameter int SAMPLE_BITS = DEF_SAMPLE_BITS) ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [CHAN_W-1:0]             channel;

	modport source (output valid, output sample_in, output channel, input ready);
	modport sink   (input valid, input sample_in, input channel, output ready);

endinterface

FILE: sv/fosf_out_if.sv
// fosf_out_if: filtered sample channel (valid/ready, sample and channel number).
// Depends on fosf_pkg.
interface fosf_out_if
	import fosf_pkg::*;
	#(parameter int SAMPLE_BITS = DEF_SAMPLE_BITS) ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [CHAN_W-1:0]             channel_out;

	modport source (output valid, output sample_out, output channel_out, input ready);
	modport sink   (input valid, input sample_out, input channel_out, output ready);

endinterface

FILE: sv/fosf_cfg_if.sv
// fosf_cfg_if: configuration write channel (valid/ready, register index, data).
// Depends on fosf_pkg.
interface fosf_cfg_if
	import fosf_pkg::*;
	();

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);

endinterface

FILE: sv/fosf_ram.sv
// fosf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fosf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/first_order_shelving_filter_top.sv
// First-order low/high shelving filter around a first-order allpass section.
// One transaction is taken at a time: a sample is accepted, then one shared
// signed 23x33 multiplier is used three times (c*x, c*y, H0/2*(x+-y)), each product
// followed by a round/saturate step; the result register is loaded in ST_ADD_OUT,
// which waits while the previous result is unaccepted, and the next sample can be
// accepted in ST_IDLE. The result register lets a new sample start while the
// previous result waits on the output. Per-channel allpass delays live in a small
// RAM with one valid flag per channel, cleared by reset, so no clearing pass is needed.
// Depends on fosf_pkg, fosf_in_if, fosf_out_if, fosf_cfg_if and fosf_ram.
module first_order_shelving_filter_top
	import fosf_pkg::*;
	#(
	parameter int CHANNELS    = DEF_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic   clk,
	input  logic   arst_n,
	fosf_in_if.sink    smp_in,
	fosf_out_if.source smp_out,
	fosf_cfg_if.sink   cfg
);

	localparam int AW     = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int SB     = SAMPLE_BITS;
	localparam int OPA_W  = COEF_W;
	localparam int OPB_W  = DLY_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int R22_W  = PROD_W - COEF_FRAC;
	localparam int Y_W    = R22_W + 1;
	localparam int R16_W  = PROD_W - GAIN_FRAC;
	localparam int O_W    = R16_W + 1;
	localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [PROD_W-1:0] HALF_G = PROD_W'(1) <<< (GAIN_FRAC - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_CX,
		ST_ADD_Y,
		ST_MUL_CY,
		ST_ADD_D,
		ST_MUL_HM,
		ST_ADD_OUT
	} state_t;

	state_t                    state_q;
	logic signed [COEF_W-1:0]  coef_q;
	logic signed [GAIN_W-1:0]  gain_q;
	logic [KIND_W-1:0]         kind_q;
	logic signed [SB-1:0]      x_q;
	logic [CHAN_W-1:0]         chf_q;
	logic [AW-1:0]             ch_q;
	logic signed [DLY_W-1:0]   d_q;
	logic signed [DLY_W-1:0]   y_q;
	logic signed [OPB_W-1:0]   mix_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [CHANNELS-1:0]       dvld_q;
	logic                      out_vld_q;
	logic signed [SB-1:0]      out_smp_q;
	logic [CHAN_W-1:0]         out_ch_q;

	logic [6:0]                ch_t;
	logic [AW-1:0]             ch_idx;
	logic [DLY_W-1:0]          ram_rdata;
	logic                      ram_we;
	logic signed [DLY_W-1:0]   nd;
	logic signed [OPB_W-1:0]   x_ext;
	logic signed [OPB_W-1:0]   y_ext;
	logic signed [OPA_W-1:0]   opa;
	logic signed [OPB_W-1:0]   opb;
	logic signed [PROD_W-1:0]  mul;
	logic signed [PROD_W-1:0]  rc_sum;
	logic signed [PROD_W-1:0]  rg_sum;
	logic signed [R22_W-1:0]   r22;
	logic signed [R16_W-1:0]   r16;
	logic signed [Y_W-1:0]     y_sum;
	logic signed [Y_W-1:0]     nd_sum;
	logic signed [O_W-1:0]     o_sum;
	logic                      in_acc;
	logic                      out_load;

	function automatic logic signed [DLY_W-1:0] sat_d(input logic signed [Y_W-1:0] v);
		logic [Y_W-DLY_W:0] hi;
		hi = v[Y_W-1:DLY_W-1];
		if ((&hi) || !(|hi)) begin
			return v[DLY_W-1:0];
		end
		return v[Y_W-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}};
	endfunction

	function automatic logic signed [SB-1:0] sat_s(input logic signed [O_W-1:0] v);
		logic [O_W-SB:0] hi;
		hi = v[O_W-1:SB-1];
		if ((&hi) || !(|hi)) begin
			return v[SB-1:0];
		end
		return v[O_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
	endfunction

	assign in_acc       = smp_in.valid && smp_in.ready;
	assign smp_in.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign out_load     = (state_q == ST_ADD_OUT) && (!out_vld_q || smp_out.ready);

	assign smp_out.valid       = out_vld_q;
	assign smp_out.sample_out  = out_smp_q;
	assign smp_out.channel_out = out_ch_q;

	// channel number folded onto the delay table
	always_comb begin
		ch_t = 7'(smp_in.channel);
		for (int i = 0; i < 8; i++) begin
			if (ch_t >= 7'(CHANNELS)) begin
				ch_t = ch_t - 7'(CHANNELS);
			end
		end
		ch_idx = ch_t[AW-1:0];
	end

	assign x_ext = {{(OPB_W-SB){x_q[SB-1]}}, x_q};
	assign y_ext = {y_q[DLY_W-1], y_q};

	always_comb begin
		opa = coef_q;
		opb = x_ext;
		unique case (state_q)
			ST_MUL_CY: begin
				opb = y_ext;
			end
			ST_MUL_HM: begin
				opa = {{(OPA_W-GAIN_W){gain_q[GAIN_W-1]}}, gain_q};
				opb = mix_q;
			end
			default: begin
			end
		endcase
	end

	assign mul    = opa * opb;
	assign rc_sum = prod_q + HALF_C;
	assign rg_sum = prod_q + HALF_G;
	assign r22    = rc_sum[PROD_W-1:COEF_FRAC];
	assign r16    = rg_sum[PROD_W-1:GAIN_FRAC];
	assign y_sum  = {r22[R22_W-1], r22} + {{(Y_W-DLY_W){d_q[DLY_W-1]}}, d_q};
	assign nd_sum = {{(Y_W-SB){x_q[SB-1]}}, x_q} - {r22[R22_W-1], r22};
	assign o_sum  = {{(O_W-SB){x_q[SB-1]}}, x_q} + {r16[R16_W-1], r16};
	assign nd     = sat_d(nd_sum);
	assign ram_we = (state_q == ST_ADD_D);

	fosf_ram #(
		.WIDTH (DLY_W),
		.DEPTH (CHANNELS)
	) u_dly_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_q),
		.wdata (nd),
		.raddr (ch_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			coef_q    <= '0;
			gain_q    <= '0;
			kind_q    <= '0;
			x_q       <= '0;
			chf_q     <= '0;
			ch_q      <= '0;
			d_q       <= '0;
			y_q       <= '0;
			mix_q     <= '0;
			prod_q    <= '0;
			dvld_q    <= '0;
			out_vld_q <= 1'b0;
			out_smp_q <= '0;
			out_ch_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_COEFF: coef_q <= cfg.data[COEF_W-1:0];
					REG_GAIN:  gain_q <= cfg.data[GAIN_W-1:0];
					REG_KIND:  kind_q <= cfg.data[KIND_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (smp_out.valid && smp_out.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q     <= smp_in.sample_in;
						chf_q   <= smp_in.channel;
						ch_q    <= ch_idx;
						state_q <= ST_MUL_CX;
					end
				end
				ST_MUL_CX: begin
					prod_q  <= mul;
					d_q     <= dvld_q[ch_q] ? ram_rdata : '0;
					state_q <= ST_ADD_Y;
				end
				ST_ADD_Y: begin
					y_q     <= sat_d(y_sum);
					state_q <= ST_MUL_CY;
				end
				ST_MUL_CY: begin
					prod_q  <= mul;
					mix_q   <= (kind_q == KIND_HIGH) ? (x_ext - y_ext) : (x_ext + y_ext);
					state_q <= ST_ADD_D;
				end
				ST_ADD_D: begin
					dvld_q[ch_q] <= 1'b1;
					state_q      <= ST_MUL_HM;
				end
				ST_MUL_HM: begin
					prod_q  <= mul;
					state_q <= ST_ADD_OUT;
				end
				ST_ADD_OUT: begin
					if (out_load) begin
						out_smp_q <= sat_s(o_sum);
						out_ch_q  <= chf_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/sv/tb_fosf_checker.sv
// tb_fosf_checker: watches the sample, result and register channels of the shelving
// filter, predicts every result and compares it with what the block returns.
// Depends on fosf_pkg.
module tb_fosf_checker
	import fosf_pkg::*;
	#(
	parameter int CHANNELS    = DEF_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic [CHAN_W-1:0]             in_channel,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [SAMPLE_BITS-1:0] out_sample,
	input  logic [CHAN_W-1:0]             out_channel,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output int                            mismatch_count,
	output int                            pending_count,
	output int                            checked_count
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CHAN_W-1:0]             channel;
	} shelf_out_t;

	longint     delay_state [CHANNELS];
	longint     coeff_val;
	longint     gain_val;
	logic       kind_val;
	shelf_out_t filtered_q [$];
	shelf_out_t oldest;

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// round half up, then arithmetic shift
	function automatic longint round_shr(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic shelf_out_t filter_sample(input logic signed [SAMPLE_BITS-1:0] x_in,
	                                             input logic [CHAN_W-1:0] ch);
		shelf_out_t res;
		longint     x;
		longint     y;
		longint     nd;
		longint     mix;
		longint     r;
		int         idx;
		x   = longint'(x_in);
		idx = int'(ch) % CHANNELS;
		y   = clip(round_shr(coeff_val * x, COEF_FRAC) + delay_state[idx], DLY_W);
		nd  = clip(x - round_shr(coeff_val * y, COEF_FRAC), DLY_W);
		delay_state[idx] = nd;
		mix = (kind_val == KIND_HIGH) ? (x - y) : (x + y);
		r   = clip(x + round_shr(gain_val * mix, GAIN_FRAC), SAMPLE_BITS);
		res.sample  = r[SAMPLE_BITS-1:0];
		res.channel = ch;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) delay_state[i] = 0;
			coeff_val      = 0;
			gain_val       = 0;
			kind_val       = 1'b0;
			filtered_q.delete();
			mismatch_count = 0;
			pending_count  = 0;
			checked_count  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COEFF: coeff_val = longint'($signed(cfg_data[COEF_W-1:0]));
					REG_GAIN:  gain_val  = longint'($signed(cfg_data[GAIN_W-1:0]));
					REG_KIND:  kind_val  = cfg_data[0];
					default: ;
				endcase
			end
			// compare before pushing: a result never belongs to a sample taken this edge
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: result without pending sample: sample=%0d channel=%0d",
					         $time, out_sample, out_channel);
					mismatch_count++;
				end else begin
					oldest = filtered_q.pop_front();
					checked_count++;
					if (out_sample !== oldest.sample) begin
						$display("%0t: sample_out mismatch: expected %0d actual %0d",
						         $time, oldest.sample, out_sample);
						mismatch_count++;
					end
					if (out_channel !== oldest.channel) begin
						$display("%0t: channel_out mismatch: expected %0d actual %0d",
						         $time, oldest.channel, out_channel);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				filtered_q.push_back(filter_sample(in_sample, in_channel));
			pending_count = filtered_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_first_order_shelving_filter_top.sv
// tb_first_order_shelving_filter_top: drives samples and register writes into the
// shelving filter with random gaps and output stalls; the checker judges results.
// Depends on fosf_pkg, the three channel interfaces, the block and tb_fosf_checker.
module tb_first_order_shelving_filter_top
	import fosf_pkg::*;
	;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS        = DEF_CHANNELS;
	localparam int SAMPLE_BITS     = DEF_SAMPLE_BITS;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 228;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 4000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
	localparam logic [KIND_W-1:0] KIND_LOW = 1'b0;

	logic clk;
	logic arst_n;
	logic hold_request;
	logic rx_stall_en;
	int   sent_count;
	int   cfg_count;
	int   mismatch_count;
	int   pending_count;
	int   checked_count;
	int   stall_left;

	fosf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_in_if ();
	fosf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_out_if ();
	fosf_cfg_if                              cfg_if ();

	first_order_shelving_filter_top #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp_in  (smp_in_if),
		.smp_out (smp_out_if),
		.cfg     (cfg_if)
	);

	tb_fosf_checker #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (smp_in_if.valid),
		.in_ready       (smp_in_if.ready),
		.in_sample      (smp_in_if.sample_in),
		.in_channel     (smp_in_if.channel),
		.out_valid      (smp_out_if.valid),
		.out_ready      (smp_out_if.ready),
		.out_sample     (smp_out_if.sample_out),
		.out_channel    (smp_out_if.channel_out),
		.cfg_valid      (cfg_if.valid),
		.cfg_ready      (cfg_if.ready),
		.cfg_index      (cfg_if.index),
		.cfg_data       (cfg_if.data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short, now and then long
	function automatic int random_gap_len();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 9))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2, 3:    return SAMPLE_BITS'($urandom_range(0, 511)) - SAMPLE_BITS'(256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x,
	                           input logic [CHAN_W-1:0] ch);
		smp_in_if.valid     = 1'b1;
		smp_in_if.sample_in = x;
		smp_in_if.channel   = ch;
		do @(posedge clk); while (!smp_in_if.ready);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		smp_in_if.valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		smp_in_if.valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// unused upper data bits and the spare index carry junk; both must be ignored
	task automatic configure(input logic [COEF_W-1:0] c, input logic [GAIN_W-1:0] g,
	                         input logic [KIND_W-1:0] k);
		logic [CFG_DATA_W-1:0] word;
		wait_drained();
		write_reg(REG_COEFF, c);
		word = CFG_DATA_W'($urandom);
		word[GAIN_W-1:0] = g;
		write_reg(REG_GAIN, word);
		word = CFG_DATA_W'($urandom);
		word[KIND_W-1:0] = k;
		write_reg(REG_KIND, word);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_if.valid = 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		logic hold_done;
		hold_done        = 1'b0;
		smp_out_if.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && rx_stall_en && $urandom_range(0, 5) == 0) begin
				stall_left = random_gap_len();
			end
			if (stall_left > 0) begin
				smp_out_if.ready = 1'b0;
				stall_left--;
			end else begin
				smp_out_if.ready = 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((smp_in_if.valid && smp_in_if.ready) || (smp_out_if.valid && smp_out_if.ready) ||
			    (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles, %0d results outstanding",
		         $time, WATCHDOG_LIMIT, pending_count);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic burst;
		arst_n              = 1'b0;
		hold_request        = 1'b0;
		rx_stall_en         = 1'b0;
		sent_count          = 0;
		cfg_count           = 0;
		smp_in_if.valid     = 1'b0;
		smp_in_if.sample_in = '0;
		smp_in_if.channel   = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = REG_COEFF;
		cfg_if.data         = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings give unity response
		send_sample(SMP_MAX, 3'd0);
		send_sample(SMP_MIN, 3'd1);
		send_sample('0, 3'd2);
		send_sample('1, 3'd3);

		configure(COEF_MAX, GAIN_MAX, KIND_LOW);
		send_sample(SMP_MAX, 3'd4);
		send_sample(SMP_MAX, 3'd4);
		send_sample(SMP_MAX, 3'd4);
		send_sample(SMP_MIN, 3'd5);
		send_sample(SMP_MIN, 3'd5);
		send_sample(SAMPLE_BITS'(1), 3'd6);

		configure(COEF_MIN, GAIN_MIN, KIND_HIGH);
		send_sample(SMP_MAX, 3'd7);
		send_sample(SMP_MIN, 3'd7);
		send_sample(SMP_MAX, 3'd7);
		send_sample('0, 3'd0);

		configure('0, GAIN_MAX, KIND_HIGH);
		send_sample(SMP_MIN, 3'd1);
		send_sample(SMP_MAX, 3'd2);
		send_sample(SMP_MIN, 3'd4);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: configure(COEF_MAX, GAIN_MIN, KIND_LOW);
				1: configure(COEF_MIN, GAIN_MAX, KIND_HIGH);
				default: configure(COEF_W'($urandom),
				                   $urandom_range(0, 1) ? GAIN_W'($urandom)
				                   : GAIN_W'($urandom_range(0, 131071)) - GAIN_W'(65536),
				                   KIND_W'($urandom));
			endcase
			rx_stall_en = (phase % 3 != 2);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				burst = (phase == 2 && i >= 40 && i < 80);
				if (phase == 2 && i == 40) hold_request = 1'b1;
				if (phase == 4 && i == ITEMS_PER_PHASE / 2) wait_drained();
				send_sample(random_sample(), CHAN_W'($urandom));
				if (!burst && $urandom_range(0, 99) < 35) pause_sender(random_gap_len());
			end
		end

		smp_in_if.valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d samples on %0d channels over %0d filter settings, %0d register writes.",
		         sent_count, CHANNELS, NUM_PHASES + 4, cfg_count);
		$display("Checked %0d results with %0d mismatches.", checked_count, mismatch_count);
		if (mismatch_count == 0 && pending_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
